// ===== hdl/cfr_pkg.sv =====
// ----------------------------------------------------------------------------
// cfr_pkg
// Types and constants shared by the command frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

   localparam int unsigned MAX_DATA       = 16;
   localparam int unsigned FRAME_OVERHEAD = 3;
   localparam int unsigned HIGHEST_CMD    = 4;

   localparam logic [7:0] MAX_LEN    = 8'(MAX_DATA + FRAME_OVERHEAD);
   localparam logic [7:0] MIN_LEN    = 8'(FRAME_OVERHEAD);
   localparam logic [7:0] TOP_CMD    = 8'(HIGHEST_CMD);

   localparam logic [1:0] PH_CMD  = 2'd0;
   localparam logic [1:0] PH_LEN  = 2'd1;
   localparam logic [1:0] PH_DATA = 2'd2;
   localparam logic [1:0] PH_SUM  = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BAD_CMD = 2'd1;
   localparam logic [1:0] ST_BAD_SUM = 2'd2;
   localparam logic [1:0] ST_BAD_LEN = 2'd3;

   typedef struct packed {
      logic       is_frame_end;
      logic [7:0] frame_command;
      logic [7:0] data_value;
      logic [3:0] data_index;
      logic [1:0] frame_status;
   } result_type;

endpackage

// ===== hdl/cfr_if.sv =====
// ----------------------------------------------------------------------------
// cfr_req_if / cfr_rsp_if
// Valid/ready channels for received bytes and parse results.
// ----------------------------------------------------------------------------
interface cfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfr_rsp_if;
   logic       valid;
   logic       ready;
   logic       is_frame_end;
   logic [7:0] frame_command;
   logic [7:0] data_value;
   logic [3:0] data_index;
   logic [1:0] frame_status;

   modport source (output valid, output is_frame_end, output frame_command,
                   output data_value, output data_index, output frame_status,
                   input ready);
   modport sink   (input valid, input is_frame_end, input frame_command,
                   input data_value, input data_index, input frame_status,
                   output ready);
endinterface

// ===== hdl/cfr_parser.sv =====
// ----------------------------------------------------------------------------
// cfr_parser
// Frame parse state and the result decode for one byte per step.
// ----------------------------------------------------------------------------
module cfr_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          rx_byte,
   output logic                has_result,
   output cfr_pkg::result_type result
);
   import cfr_pkg::*;

   logic [1:0] phase_ff,    phase_in;
   logic [7:0] command_ff,  command_in;
   logic [7:0] left_ff,     left_in;
   logic [3:0] position_ff, position_in;
   logic [7:0] xor_ff,      xor_in;
   logic [7:0] left_dec;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_CMD;
         command_ff  <= '0;
         left_ff     <= '0;
         position_ff <= '0;
         xor_ff      <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         command_ff  <= command_in;
         left_ff     <= left_in;
         position_ff <= position_in;
         xor_ff      <= xor_in;
      end
   end

   assign left_dec = left_ff - 8'd1;

   always_comb begin
      phase_in            = phase_ff;
      command_in          = command_ff;
      left_in             = left_ff;
      position_in         = position_ff;
      xor_in              = xor_ff;
      has_result          = 1'b0;
      result.is_frame_end = 1'b0;
      result.frame_command = command_ff;
      result.data_value   = '0;
      result.data_index   = '0;
      result.frame_status = ST_OK;
      unique case (phase_ff)
         PH_CMD: begin
            command_in  = rx_byte;
            xor_in      = rx_byte;
            left_in     = '0;
            position_in = '0;
            phase_in    = PH_LEN;
         end
         PH_LEN: begin
            xor_in = xor_ff ^ rx_byte;
            if (rx_byte > MAX_LEN || rx_byte < MIN_LEN) begin
               has_result          = 1'b1;
               result.is_frame_end = 1'b1;
               result.frame_status = ST_BAD_LEN;
               phase_in            = PH_CMD;
            end else begin
               left_in     = rx_byte - MIN_LEN;
               position_in = '0;
               phase_in    = (rx_byte == MIN_LEN) ? PH_SUM : PH_DATA;
            end
         end
         PH_DATA: begin
            has_result        = 1'b1;
            result.data_value = rx_byte;
            result.data_index = position_ff;
            xor_in            = xor_ff ^ rx_byte;
            position_in       = position_ff + 4'd1;
            left_in           = left_dec;
            if (left_dec == 8'd0) begin
               phase_in = PH_SUM;
            end
         end
         PH_SUM: begin
            has_result          = 1'b1;
            result.is_frame_end = 1'b1;
            phase_in            = PH_CMD;
            priority if (command_ff > TOP_CMD) begin
               result.frame_status = ST_BAD_CMD;
            end else if (xor_ff != rx_byte) begin
               result.frame_status = ST_BAD_SUM;
            end else begin
               result.frame_status = ST_OK;
            end
         end
         default: begin
            phase_in = PH_CMD;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_cmd_then_len: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_CMD |=> phase_ff == PH_LEN)
      else $error("command byte did not move parser to length");

   a_sum_ends_frame: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_SUM |-> has_result && result.is_frame_end)
      else $error("checksum byte gave no frame end");

   a_data_has_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> left_ff != 8'd0)
      else $error("data phase with no bytes left");

   a_end_back_to_cmd: assert property (@(posedge clock) disable iff (reset)
      step && has_result && result.is_frame_end |=> phase_ff == PH_CMD)
      else $error("frame end did not return to command phase");
`endif

endmodule

// ===== hdl/command_frame_receiver_top.sv =====
// path: an item is registered at acceptance, and the parse step then loads its
//    result, if it gives one, into the result register, which offers it on the
//    result channel until it is taken
// throughput: one item per cycle while the result channel does not stall, with
//    the parse step combinational between the input and result registers
// reset: synchronous; clears both valid flags and the parse state
// ----------------------------------------------------------------------------
// command_frame_receiver_top
// Parses length-prefixed command frames with an XOR checksum, one byte a step.
// ----------------------------------------------------------------------------
module command_frame_receiver_top (
   input  logic      clock,
   input  logic      reset,
   cfr_req_if.sink   req_if,
   cfr_rsp_if.source rsp_if
);
   import cfr_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   result_type out_ff;
   logic       has_result;
   result_type result;
   logic       out_free;
   logic       advance;

   assign out_free = !out_valid_ff || rsp_if.ready;
   assign advance  = in_valid_ff && (!has_result || out_free);
   assign req_if.ready = !in_valid_ff || advance;

   cfr_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .rx_byte    (in_byte_ff),
      .has_result (has_result),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         in_byte_ff <= req_if.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= advance && has_result;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && has_result) begin
         out_ff <= result;
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.is_frame_end  = out_ff.is_frame_end;
   assign rsp_if.frame_command = out_ff.frame_command;
   assign rsp_if.data_value    = out_ff.data_value;
   assign rsp_if.data_index    = out_ff.data_index;
   assign rsp_if.frame_status  = out_ff.frame_status;

`ifndef SYNTHESIS
   a_no_lost_result: assert property (@(posedge clock) disable iff (reset)
      advance && has_result |-> out_free)
      else $error("result written over a pending one");

   a_step_consumes: assert property (@(posedge clock) disable iff (reset)
      advance && !(req_if.valid && req_if.ready) |=> !in_valid_ff)
      else $error("input register kept a consumed item");

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("stalled item changed");
`endif

endmodule

// ===== tb/cfr_checker.sv =====
// ----------------------------------------------------------------------------
// cfr_checker
// Watches the byte and result channels of the command frame receiver, tracks
// the frame parse on its own, and compares every result item in order.
// ----------------------------------------------------------------------------
module cfr_checker (
   input  logic        clock,
   input  logic        reset,
   cfr_req_if          req_mon,
   cfr_rsp_if          rsp_mon,
   output int unsigned error_count,
   output int unsigned pending_count,
   output int unsigned data_count,
   output int unsigned end_count,
   output logic [3:0]  status_seen
);
   import cfr_pkg::*;

   logic [1:0] parse_phase;
   logic [7:0] frame_cmd;
   logic [7:0] bytes_left;
   logic [3:0] data_pos;
   logic [7:0] frame_xor;

   result_type frame_results[$];

   task automatic parse_byte(input logic [7:0] b);
      result_type r;
      r = '0;
      r.frame_command = frame_cmd;
      case (parse_phase)
         PH_CMD: begin
            frame_cmd   = b;
            frame_xor   = b;
            bytes_left  = '0;
            data_pos    = '0;
            parse_phase = PH_LEN;
         end
         PH_LEN: begin
            frame_xor = frame_xor ^ b;
            if (b > MAX_LEN || b < MIN_LEN) begin
               r.is_frame_end = 1'b1;
               r.frame_status = ST_BAD_LEN;
               frame_results.push_back(r);
               parse_phase = PH_CMD;
            end else begin
               bytes_left  = b - MIN_LEN;
               data_pos    = '0;
               parse_phase = (bytes_left == 0) ? PH_SUM : PH_DATA;
            end
         end
         PH_DATA: begin
            r.data_value = b;
            r.data_index = data_pos;
            frame_results.push_back(r);
            frame_xor  = frame_xor ^ b;
            data_pos   = data_pos + 4'd1;
            bytes_left = bytes_left - 8'd1;
            if (bytes_left == 0) begin
               parse_phase = PH_SUM;
            end
         end
         default: begin
            r.is_frame_end = 1'b1;
            if (frame_cmd > TOP_CMD) begin
               r.frame_status = ST_BAD_CMD;
            end else if (frame_xor != b) begin
               r.frame_status = ST_BAD_SUM;
            end else begin
               r.frame_status = ST_OK;
            end
            frame_results.push_back(r);
            parse_phase = PH_CMD;
         end
      endcase
   endtask

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         parse_phase   = PH_CMD;
         frame_cmd     = '0;
         bytes_left    = '0;
         data_pos      = '0;
         frame_xor     = '0;
         frame_results.delete();
         error_count   = 0;
         pending_count = 0;
         data_count    = 0;
         end_count     = 0;
         status_seen   = '0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (frame_results.size() == 0) begin
               $error("result item with nothing pending: end %0b cmd %0h value %0h",
                      rsp_mon.is_frame_end, rsp_mon.frame_command, rsp_mon.data_value);
               error_count++;
            end else begin
               want = frame_results.pop_front();
               check_field("is_frame_end", want.is_frame_end, rsp_mon.is_frame_end);
               check_field("frame_command", want.frame_command, rsp_mon.frame_command);
               check_field("data_value", want.data_value, rsp_mon.data_value);
               check_field("data_index", want.data_index, rsp_mon.data_index);
               check_field("frame_status", want.frame_status, rsp_mon.frame_status);
               if (rsp_mon.is_frame_end) begin
                  end_count++;
                  status_seen[rsp_mon.frame_status] = 1'b1;
               end else begin
                  data_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            parse_byte(req_mon.rx_byte);
         end
         pending_count = frame_results.size();
      end
   end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives framed byte streams into the command frame receiver: a few directed
// frames for the corner cases, then random frames, bad lengths and loose
// bytes under changing idle and stall patterns. The checker judges results.
// ----------------------------------------------------------------------------
module testbench;
   import cfr_pkg::*;

   localparam int unsigned BYTE_TARGET = 1750;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned HOLD_CYCLES = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned idle_mode = 0;
   logic        long_hold = 1'b0;
   int unsigned hold_count = 0;
   int unsigned bytes_sent = 0;
   int unsigned cycle_count = 0;
   int unsigned error_count;
   int unsigned pending_count;
   int unsigned data_count;
   int unsigned end_count;
   logic [3:0]  status_seen;

   cfr_req_if req_if ();
   cfr_rsp_if rsp_if ();

   command_frame_receiver_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   cfr_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_if),
      .rsp_mon       (rsp_if),
      .error_count   (error_count),
      .pending_count (pending_count),
      .data_count    (data_count),
      .end_count     (end_count),
      .status_seen   (status_seen)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   function automatic int unsigned req_idle_pct();
      case (idle_mode)
         1: return 56;
         3: return 15;
         default: return 0;
      endcase
   endfunction

   function automatic int unsigned rsp_stall_pct();
      case (idle_mode)
         2: return 56;
         3: return 15;
         default: return 0;
      endcase
   endfunction

   // result side: random stalls plus one long hold-off
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold && hold_count < HOLD_CYCLES) begin
            rsp_if.ready <= 1'b0;
            hold_count++;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct());
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct()) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.rx_byte <= b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len,
                             input bit bad_sum);
      logic [7:0] sum;
      logic [7:0] b;
      sum = cmd ^ len;
      send_byte(cmd);
      send_byte(len);
      if (len >= MIN_LEN && len <= MAX_LEN) begin
         repeat (len - MIN_LEN) begin
            b   = 8'($urandom_range(255));
            sum = sum ^ b;
            send_byte(b);
         end
         if (bad_sum) begin
            sum = sum ^ 8'($urandom_range(255, 1));
         end
         send_byte(sum);
      end
   endtask

   task automatic send_random_frame();
      int unsigned pick;
      logic [7:0]  cmd;
      logic [7:0]  len;
      pick = $urandom_range(99);
      if ($urandom_range(9) == 0) begin
         cmd = 8'($urandom_range(255));
      end else begin
         cmd = 8'($urandom_range(TOP_CMD));
      end
      if (pick < 82) begin
         send_frame(cmd, 8'($urandom_range(MAX_LEN, MIN_LEN)), $urandom_range(6) == 0);
      end else if (pick < 94) begin
         if ($urandom_range(1) == 0) begin
            len = 8'($urandom_range(MIN_LEN - 1));
         end else begin
            len = 8'($urandom_range(255, MAX_LEN + 1));
         end
         send_frame(cmd, len, 1'b0);
      end else begin
         // stray bytes knock the parser out of step with the framing
         repeat ($urandom_range(5, 1)) send_byte(8'($urandom));
      end
   endtask

   initial begin
      int unsigned mode;
      req_if.valid   = 1'b0;
      req_if.rx_byte = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      send_frame(8'd0, MIN_LEN, 1'b0);           // empty payload
      send_frame(TOP_CMD, 8'd4, 1'b0);
      send_frame(TOP_CMD + 8'd1, MIN_LEN, 1'b1); // bad command beats bad checksum
      send_frame(8'd1, 8'd5, 1'b1);
      send_frame(8'd2, MIN_LEN - 8'd1, 1'b0);
      send_frame(8'hff, 8'd0, 1'b0);
      send_frame(8'd3, MAX_LEN + 8'd1, 1'b0);
      send_frame(8'd4, 8'hff, 1'b0);

      long_hold = 1'b1;
      for (mode = 0; mode < 4; mode++) begin
         idle_mode = mode;
         while (bytes_sent < (mode + 1) * BYTE_TARGET / 4) send_random_frame();
      end

      @(negedge clock);
      req_if.valid <= 1'b0;
      idle_mode = 0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);

      $display("run: %0d bytes in, %0d data and %0d frame-end results checked",
               bytes_sent, data_count, end_count);
      $display("run: frame status codes seen (bad len, bad sum, bad cmd, ok) = %b",
               status_seen);
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
